/* rtl/hsre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsre_pkg: shared types and constants
// Request kinds, result status codes and the control word that travels
// with a request from the regroup stage to the output stage.
// ----------------------------------------------------------------------------
package hsre_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_CHAR = 2'd1,
        ACT_END  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_SYMBOL  = 3'd0,
        ST_INVALID = 3'd1,
        ST_END_OK  = 3'd2,
        ST_END_ODD = 3'd3,
        ST_END_ERR = 3'd4
    } status_t;

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_F = 8'h66;

    localparam logic [3:0] NIB_ALPHA_OFS = 4'd9;

    localparam logic [2:0] WIDTH_RESET = 3'd6;
    localparam logic [2:0] WIDTH_MIN   = 3'd4;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned REG_SEL = 2;  // paddr bit that picks the register word

    typedef struct packed {
        logic    valid;
        status_t status;
        logic    last;
        logic    symbol;  // take the character from the table read
    } res_ctrl_t;

endpackage : hsre_pkg
`default_nettype wire

/* rtl/hex_to_symbol_regroup_encoder_core.sv */
`default_nettype none
// Path: an accepted request passes the lookup register, then the output register.
// Throughput: one request per cycle unless m_tready stalls; the single table
//   read port, lookup and output registers keep the pipe full under back-pressure.
// Reset: synchronous active-low aresetn clears stream state and valids and
//   sets index_width to 6; the symbol table is not cleared.
// ----------------------------------------------------------------------------
// hex_to_symbol_regroup_encoder_core: hex text to table symbol encoder
// Regroups hex nibbles into index_width-bit table indices (at least four bits) and emits the
// stored symbol characters, with end-of-stream status reporting.
// ----------------------------------------------------------------------------
module hex_to_symbol_regroup_encoder_core #(
    parameter int unsigned TABLE_DEPTH = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,  // text_char, table_index, table_char
    input  wire logic [1:0]                    s_tuser,  // action
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // out_char
    output logic [2:0]                         m_tuser,  // status
    output logic                               m_tlast,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hsre_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [hsre_pkg::PDATA_W-1:0]  pwdata,
    output logic [hsre_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import hsre_pkg::*;

    logic       accept;
    logic       cfg_we;
    action_t    action;
    res_ctrl_t  ctrl;
    logic [6:0] rd_idx;
    logic [7:0] rd_data;
    logic [2:0] width;

    assign action = action_t'(s_tuser);
    assign accept = s_tvalid && s_tready;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[REG_SEL];
    assign prdata = paddr[REG_SEL] ? '0 : {{(PDATA_W-3){1'b0}}, width};

    hsre_regroup #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_regroup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .action    (action),
        .text_char (s_tdata[7:0]),
        .cfg_we    (cfg_we),
        .cfg_width (pwdata[2:0]),
        .ctrl      (ctrl),
        .rd_idx    (rd_idx),
        .width     (width)
    );

    hsre_symtab #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_symtab (
        .aclk    (aclk),
        .we      (accept && (action == ACT_LOAD)),
        .wr_idx  (s_tdata[14:8]),
        .wr_data (s_tdata[22:15]),
        .re      (accept),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    hsre_outstage u_outstage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .ctrl     (ctrl),
        .rd_data  (rd_data),
        .ready    (s_tready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_char   (m_tdata),
        .m_status (m_tuser),
        .m_last   (m_tlast)
    );

endmodule : hex_to_symbol_regroup_encoder_core
`default_nettype wire

/* rtl/hsre_regroup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsre_regroup: hex decode and bit regrouping
// Decodes a character to a nibble, shifts it into the accumulator and picks
// the oldest index_width bits (at least four) as a table index once enough are pending.
// ----------------------------------------------------------------------------
module hsre_regroup #(
    parameter int unsigned TABLE_DEPTH = 128
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire hsre_pkg::action_t   action,
    input  wire logic [7:0]          text_char,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_width,
    output hsre_pkg::res_ctrl_t      ctrl,
    output logic [6:0]               rd_idx,
    output logic [2:0]               width
);
    import hsre_pkg::*;

    logic [2:0] width_reg, width_next;
    logic [9:0] acc_reg, acc_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       parity_reg, parity_next;
    logic       aborted_reg, aborted_next;

    logic [2:0] w;
    logic       is_digit, is_alpha;
    logic [3:0] nib;
    logic [9:0] acc_shift;
    logic [3:0] cnt_sum, cnt_left;
    logic       emit;
    logic [9:0] shifted;
    logic [6:0] idx;
    logic       in_range;

    always_comb begin
        w        = (width_reg < WIDTH_MIN) ? WIDTH_MIN : width_reg;
        is_digit = (text_char >= CHAR_0) && (text_char <= CHAR_9);
        is_alpha = (text_char >= CHAR_A) && (text_char <= CHAR_F);
        nib      = is_alpha ? (text_char[3:0] + NIB_ALPHA_OFS) : text_char[3:0];

        acc_shift = {acc_reg[5:0], nib};
        cnt_sum   = cnt_reg + 4'd4;
        emit      = cnt_sum >= {1'b0, w};
        cnt_left  = cnt_sum - {1'b0, w};
        // after an emit fewer than four bits remain
        shifted   = acc_shift >> cnt_left[1:0];
        idx       = shifted[6:0] & ~(7'h7F << w);
        in_range  = {1'b0, idx} < 8'(TABLE_DEPTH);

        width_next   = width_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        parity_next  = parity_reg;
        aborted_next = aborted_reg;
        ctrl         = '0;

        if (cfg_we) begin
            width_next = cfg_width;
            acc_next   = '0;
            cnt_next   = '0;
        end else if (accept) begin
            case (action)
                ACT_END: begin
                    ctrl.valid = 1'b1;
                    ctrl.last  = 1'b1;
                    if (aborted_reg) begin
                        ctrl.status = ST_END_ERR;
                    end else if (parity_reg) begin
                        ctrl.status = ST_END_ODD;
                    end else begin
                        ctrl.status = ST_END_OK;
                    end
                    acc_next     = '0;
                    cnt_next     = '0;
                    parity_next  = 1'b0;
                    aborted_next = 1'b0;
                end
                ACT_CHAR: begin
                    if (!aborted_reg) begin
                        if (!(is_digit || is_alpha)) begin
                            ctrl.valid   = 1'b1;
                            ctrl.status  = ST_INVALID;
                            aborted_next = 1'b1;
                            acc_next     = '0;
                            cnt_next     = '0;
                        end else begin
                            parity_next = ~parity_reg;
                            if (emit) begin
                                ctrl.valid  = 1'b1;
                                ctrl.status = ST_SYMBOL;
                                ctrl.symbol = in_range;
                                acc_next    = acc_shift & ~(10'h3FF << cnt_left[1:0]);
                                cnt_next    = cnt_left;
                            end else begin
                                acc_next = acc_shift;
                                cnt_next = cnt_sum;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign rd_idx = idx;
    assign width  = width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            parity_reg  <= 1'b0;
            aborted_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            parity_reg  <= parity_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule : hsre_regroup
`default_nettype wire

/* rtl/hsre_symtab.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsre_symtab: symbol table
// Single write port for load requests, one registered read port.
// ----------------------------------------------------------------------------
module hsre_symtab #(
    parameter int unsigned TABLE_DEPTH = 128
) (
    input  wire logic       aclk,
    input  wire logic       we,
    input  wire logic [6:0] wr_idx,
    input  wire logic [7:0] wr_data,
    input  wire logic       re,
    input  wire logic [6:0] rd_idx,
    output logic [7:0]      rd_data
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [7:0] mem [TABLE_DEPTH];
    logic [7:0] rd_data_reg;
    logic       wr_ok;

    assign wr_ok = we && ({1'b0, wr_idx} < 8'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
    end

    // out-of-range indices are zeroed downstream
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : hsre_symtab
`default_nettype wire

/* rtl/hsre_outstage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsre_outstage: result pipeline
// Lookup stage aligned with the table read, then the output register.
// ----------------------------------------------------------------------------
module hsre_outstage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire hsre_pkg::res_ctrl_t ctrl,
    input  wire logic [7:0]          rd_data,
    output logic                     ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_char,
    output logic [2:0]               m_status,
    output logic                     m_last
);
    import hsre_pkg::*;

    res_ctrl_t  a_ctrl_reg, a_ctrl_next;
    logic       b_valid_reg, b_valid_next;
    logic [7:0] b_char_reg, b_char_next;
    status_t    b_status_reg, b_status_next;
    logic       b_last_reg, b_last_next;
    logic       advance;

    always_comb begin
        advance = a_ctrl_reg.valid && (!b_valid_reg || m_ready);
        ready   = !a_ctrl_reg.valid || advance;

        a_ctrl_next = a_ctrl_reg;
        if (accept) begin
            a_ctrl_next = ctrl;
        end else if (advance) begin
            a_ctrl_next.valid = 1'b0;
        end

        b_valid_next  = b_valid_reg;
        b_char_next   = b_char_reg;
        b_status_next = b_status_reg;
        b_last_next   = b_last_reg;
        if (advance) begin
            b_valid_next  = 1'b1;
            b_char_next   = a_ctrl_reg.symbol ? rd_data : 8'h00;
            b_status_next = a_ctrl_reg.status;
            b_last_next   = a_ctrl_reg.last;
        end else if (m_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctrl_reg  <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            a_ctrl_reg  <= a_ctrl_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_char_reg   <= b_char_next;
        b_status_reg <= b_status_next;
        b_last_reg   <= b_last_next;
    end

    assign m_valid  = b_valid_reg;
    assign m_char   = b_char_reg;
    assign m_status = b_status_reg;
    assign m_last   = b_last_reg;

endmodule : hsre_outstage
`default_nettype wire

/* tb/hex_to_symbol_regroup_encoder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_to_symbol_regroup_encoder_core_tb: self-checking bench for the encoder
// Fills the symbol table, then runs directed hex text and random streams at
// every index width. A scoreboard predicts each symbol and end status and
// checks the result stream. Both sides of the bus stall at random.
// ----------------------------------------------------------------------------
module hex_to_symbol_regroup_encoder_core_tb;
    import hsre_pkg::*;

    localparam int unsigned DEPTH = 128;
    localparam logic [PADDR_W-1:0] WIDTH_ADDR = '0;
    localparam int unsigned N_PHASES = 12;
    localparam int unsigned PHASE_ITEMS = 120;

    typedef struct {
        logic [7:0] out_char;
        status_t    status;
        logic       last;
    } symbol_result_t;

    // Tracks stream state and the table, predicts results in request order.
    class symbol_scoreboard;
        logic [7:0]     symbols [DEPTH];
        int unsigned    acc;
        int unsigned    cnt;
        bit             odd;
        bit             aborted;
        logic [2:0]     width;
        symbol_result_t expected_syms [$];
        int unsigned    errors;
        int unsigned    n_requests;
        int unsigned    n_results;

        function new();
            acc = 0;
            cnt = 0;
            odd = 0;
            aborted = 0;
            width = WIDTH_RESET;
            errors = 0;
            n_requests = 0;
            n_results = 0;
        endfunction

        function void set_width(logic [2:0] w);
            width = w;
            acc = 0;
            cnt = 0;
        endfunction

        function void push(logic [7:0] c, status_t st, logic l);
            symbol_result_t r;
            r.out_char = c;
            r.status = st;
            r.last = l;
            expected_syms.push_back(r);
        endfunction

        function void note_request(action_t act, logic [7:0] tch, logic [6:0] tidx,
                                   logic [7:0] tval);
            int unsigned nib;
            int unsigned w;
            int unsigned idx;
            n_requests++;
            case (act)
                ACT_LOAD: begin
                    symbols[tidx] = tval;
                end
                ACT_END: begin
                    if (aborted)
                        push(8'h00, ST_END_ERR, 1'b1);
                    else if (odd)
                        push(8'h00, ST_END_ODD, 1'b1);
                    else
                        push(8'h00, ST_END_OK, 1'b1);
                    acc = 0;
                    cnt = 0;
                    odd = 0;
                    aborted = 0;
                end
                ACT_CHAR: begin
                    if (!aborted) begin
                        if (tch >= CHAR_0 && tch <= CHAR_9) begin
                            nib = tch - CHAR_0;
                        end else if (tch >= CHAR_A && tch <= CHAR_F) begin
                            nib = tch - CHAR_A + 10;
                        end else begin
                            nib = 16;
                        end
                        if (nib > 15) begin
                            aborted = 1;
                            acc = 0;
                            cnt = 0;
                            push(8'h00, ST_INVALID, 1'b0);
                        end else begin
                            odd = !odd;
                            acc = ((acc << 4) | nib) & 32'h3FF;
                            cnt += 4;
                            w = (width < 4) ? 4 : width;
                            if (cnt >= w) begin
                                cnt -= w;
                                idx = (acc >> cnt) & ((1 << w) - 1);
                                acc &= (1 << cnt) - 1;
                                push(symbols[idx], ST_SYMBOL, 1'b0);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, int got, int exp_val);
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
                     exp_val);
            errors++;
        endtask

        task check_result(logic [7:0] c, logic [2:0] st, logic l);
            symbol_result_t e;
            n_results++;
            if (expected_syms.size() == 0) begin
                report_mismatch("unexpected result (out_char)", c, 0);
            end else begin
                e = expected_syms.pop_front();
                if (c !== e.out_char) report_mismatch("out_char", c, e.out_char);
                if (st !== e.status) report_mismatch("status", st, e.status);
                if (l !== e.last) report_mismatch("last", l, e.last);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // text_char [7:0], table_index [14:8], table_char [22:15]
    logic [1:0]  s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_char
    logic [2:0]  m_tuser;   // status
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    symbol_scoreboard sb;
    int unsigned s_idle_pct;
    int unsigned m_idle_pct;
    int unsigned n_sent;

    hex_to_symbol_regroup_encoder_core #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[hex_to_symbol_regroup_encoder_core] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    function automatic logic [7:0] hex_char(int unsigned n);
        return 8'((n < 10) ? CHAR_0 + n : CHAR_A + (n - 10));
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while ((c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_A && c <= CHAR_F));
        return c;
    endfunction

    task automatic send_request(action_t act, logic [7:0] tch, logic [6:0] tidx,
                                logic [7:0] tval);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, tval, tidx, tch};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, tch, tidx, tval);
        if (act != ACT_NONE) n_sent++;
    endtask

    task automatic send_char(logic [7:0] c);
        send_request(ACT_CHAR, c, 7'($urandom_range(127)), 8'($urandom_range(255)));
    endtask

    task automatic send_end();
        send_request(ACT_END, 8'($urandom_range(255)), 7'($urandom_range(127)),
                     8'($urandom_range(255)));
    endtask

    // Let every outstanding result come back, then wait out requests that
    // produce nothing but may still be in the pipe.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_syms.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == WIDTH_ADDR) sb.set_width(data[2:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] exp_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== exp_val) sb.report_mismatch("prdata", prdata, exp_val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One stream of hex text, mostly well formed, with the odd load,
    // bad character or unused action mixed in.
    task automatic send_stream(bit with_end);
        int unsigned len;
        int unsigned r;
        len = $urandom_range(24);
        for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 5)
                send_request(ACT_LOAD, 8'($urandom_range(255)), 7'($urandom_range(127)),
                             8'($urandom_range(255)));
            else if (r < 8)
                send_char(non_hex_char());
            else if (r < 10)
                send_request(ACT_NONE, 8'($urandom_range(255)), 7'($urandom_range(127)),
                             8'($urandom_range(255)));
            else
                send_char(hex_char($urandom_range(15)));
        end
        if (with_end) send_end();
    endtask

    logic [7:0] bad_chars [7] = '{8'h2F, 8'h3A, 8'h60, 8'h67, 8'h41, 8'h00, 8'hFF};
    logic [2:0] widths [N_PHASES] = '{3'd4, 3'd7, 3'd5, 3'd0, 3'd6, 3'd3,
                                      3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd7};

    initial begin
        int unsigned phase_start;
        sb = new();
        n_sent = 0;
        s_idle_pct = 9;
        m_idle_pct = 63;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_NONE;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apb_check(WIDTH_ADDR, PDATA_W'(WIDTH_RESET));

        // every table entry is written before any symbol can read it
        for (int unsigned i = 0; i < DEPTH; i++)
            send_request(ACT_LOAD, 8'($urandom_range(255)), 7'(i), 8'($urandom_range(255)));

        // directed: range edges of the hex digits, odd and even ends,
        // an unused action, an abort with ignored text after it
        send_char("0");
        send_char("9");
        send_char("a");
        send_char("f");
        send_char("5");
        send_request(ACT_NONE, 8'h31, 7'h7F, 8'hFF);
        send_end();
        send_char("f");
        send_char("f");
        send_end();
        send_char("3");
        send_char(8'h2F);
        send_char("b");
        send_char(8'h3A);
        send_end();
        foreach (bad_chars[i]) begin
            send_char(bad_chars[i]);
            send_end();
        end

        for (int unsigned p = 0; p < N_PHASES; p++) begin
            if (p < N_PHASES / 3) begin
                s_idle_pct = 9;
                m_idle_pct = 63;
            end else if (p < 2 * N_PHASES / 3) begin
                s_idle_pct = 63;
                m_idle_pct = 9;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            drain();
            apb_write(WIDTH_ADDR, PDATA_W'(widths[p]));
            apb_check(WIDTH_ADDR, PDATA_W'(widths[p]));
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS)
                send_stream($urandom_range(7) != 0);
            // send up to three more characters so the next width write can land mid-stream
            repeat ($urandom_range(3)) send_char(hex_char($urandom_range(15)));
        end
        send_end();
        drain();

        while (sb.expected_syms.size() != 0) begin
            sb.report_mismatch("missing result (status)", 0, sb.expected_syms[0].status);
            void'(sb.expected_syms.pop_front());
        end
        $display("covered %0d requests and %0d results over %0d width settings",
                 sb.n_requests, sb.n_results, N_PHASES + 1);
        $display("stalls on both sides, aborted and odd-length streams included");
        if (sb.errors == 0)
            $display("[hex_to_symbol_regroup_encoder_core] OK");
        else
            $display("[hex_to_symbol_regroup_encoder_core] ERROR");
        $finish;
    end

endmodule
